// ===== sv/tile_depth_tag_buffer_core_defines.svh =====
// assertion macros for the tile depth and tag buffer
`ifndef TILE_DEPTH_TAG_BUFFER_CORE_DEFINES_SVH
`define TILE_DEPTH_TAG_BUFFER_CORE_DEFINES_SVH
// implication checked on every clock, quiet in reset
`define TDTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TDTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/tdtb_pkg.sv =====
// ------------------------------------------------------------------
// tdtb_pkg
// shared types, codes and depth compare for the tile depth buffer
// ------------------------------------------------------------------
package tdtb_pkg;
	localparam int TILE_PIXELS_DEF   = 1024;
	localparam int STENCIL_WIDTH_DEF = 8;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [2:0] ACT_PIXEL     = 3'd0;
	localparam logic [2:0] ACT_CLEAR_ALL = 3'd1;
	localparam logic [2:0] ACT_CLEAR_TAG = 3'd2;
	localparam logic [2:0] ACT_PEEL      = 3'd3;
	localparam logic [2:0] ACT_ST_OR     = 3'd4;
	localparam logic [2:0] ACT_ST_AND    = 3'd5;
	localparam logic [2:0] ACT_CLR_CNT   = 3'd6;

	localparam logic [1:0] PC_OPAQUE = 2'd0;
	localparam logic [1:0] PC_PUNCH  = 2'd1;
	localparam logic [1:0] PC_TRANS  = 2'd2;
	localparam logic [1:0] PC_MOD    = 2'd3;

	localparam logic [2:0] DM_NEVER  = 3'd0;
	localparam logic [2:0] DM_LESS   = 3'd1;
	localparam logic [2:0] DM_EQUAL  = 3'd2;
	localparam logic [2:0] DM_LEQUAL = 3'd3;
	localparam logic [2:0] DM_GREATER= 3'd4;
	localparam logic [2:0] DM_NEQUAL = 3'd5;
	localparam logic [2:0] DM_GEQUAL = 3'd6;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EXEC,
		BK_SWEEP
	} bk_state_t;

	// classified word passed from front to back
	typedef struct packed {
		logic        is_pixel;
		logic        is_sweep;
		logic [2:0]  action;
		logic [1:0]  prim_class;
		logic [2:0]  cmp_mode;
		logic [31:0] depth_value;
		logic [11:0] pixel_index;
		logic [31:0] tag_value;
		logic [31:0] fill_stencil;
	} word_t;

	function automatic logic f_nan(input logic [31:0] a);
		return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
	endfunction

	// ieee single ordering; +0 and -0 equal; unordered gives false
	function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
		logic az;
		logic bz;
		az = (a[30:0] == 31'd0);
		bz = (b[30:0] == 31'd0);
		if (f_nan(a) || f_nan(b)) return 1'b0;
		if (az && bz) return 1'b0;
		if (a[31] != b[31]) return a[31];
		if (a[31]) return a[30:0] > b[30:0];
		return a[30:0] < b[30:0];
	endfunction

	function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
		if (f_nan(a) || f_nan(b)) return 1'b0;
		return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
	endfunction

	// each ordering mode is the negation of the opposite ordered compare
	function automatic logic depth_pass(input logic [2:0] m, input logic [31:0] v,
		input logic [31:0] z);
		logic lt;
		logic gt;
		logic eq;
		lt = f_lt(v, z);
		gt = f_lt(z, v);
		eq = f_eq(v, z);
		case (m)
			DM_NEVER:   return 1'b0;
			DM_LESS:    return !(gt || eq);
			DM_EQUAL:   return eq;
			DM_LEQUAL:  return !gt;
			DM_GREATER: return !(lt || eq);
			DM_NEQUAL:  return !eq;
			DM_GEQUAL:  return !lt;
			default:    return 1'b1;
		endcase
	endfunction
endpackage

// ===== sv/tdtb_front.sv =====
// ------------------------------------------------------------------
// tdtb_front
// accepts commands, classifies them and queues words for the back end
// ------------------------------------------------------------------
module tdtb_front #(
	parameter int TILE_PIXELS   = tdtb_pkg::TILE_PIXELS_DEF,
	parameter int STENCIL_WIDTH = tdtb_pkg::STENCIL_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [2:0]          action,
	input  logic [1:0]          prim_class,
	input  logic [2:0]          ztest_func,
	input  logic [31:0]         depth_value,
	input  logic [9:0]          pixel_index,
	input  logic [31:0]         tag_value,
	input  logic [7:0]          fill_stencil,
	output logic                full,
	output logic                q_valid,
	output tdtb_pkg::word_t     q_word,
	input  logic                pop
);
	localparam int QD = tdtb_pkg::QUEUE_DEPTH;
	tdtb_pkg::word_t w;
	tdtb_pkg::word_t mem_q [QD];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic [31:0] smask;

	assign smask = (STENCIL_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << STENCIL_WIDTH) - 32'd1);

	always_comb begin
		w = '0;
		w.action      = action;
		w.prim_class  = prim_class;
		w.depth_value = depth_value;
		w.pixel_index = {2'b00, pixel_index};
		w.tag_value   = tag_value;
		w.fill_stencil = {24'd0, fill_stencil} & smask;
		w.is_pixel = (action == tdtb_pkg::ACT_PIXEL) &&
			({3'b000, pixel_index} < 13'(TILE_PIXELS));
		w.is_sweep = (action == tdtb_pkg::ACT_CLEAR_ALL) || (action == tdtb_pkg::ACT_CLEAR_TAG) ||
			(action == tdtb_pkg::ACT_PEEL) || (action == tdtb_pkg::ACT_ST_OR) ||
			(action == tdtb_pkg::ACT_ST_AND);
		case (prim_class)
			tdtb_pkg::PC_PUNCH, tdtb_pkg::PC_MOD: w.cmp_mode = tdtb_pkg::DM_GEQUAL;
			tdtb_pkg::PC_TRANS: w.cmp_mode = tdtb_pkg::DM_LEQUAL;
			default:            w.cmp_mode = ztest_func;
		endcase
	end

	assign full    = (cnt_q == 2'(QD));
	assign q_valid = (cnt_q != 2'd0);
	assign q_word  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== sv/tdtb_back.sv =====
// ------------------------------------------------------------------
// tdtb_back
// runs pixel tests, control words and tile sweeps on the stores
// ------------------------------------------------------------------
`include "tile_depth_tag_buffer_core_defines.svh"
module tdtb_back #(
	parameter int TILE_PIXELS   = tdtb_pkg::TILE_PIXELS_DEF,
	parameter int STENCIL_WIDTH = tdtb_pkg::STENCIL_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  tdtb_pkg::word_t q_word,
	output logic            pop,
	output logic            idle,
	output logic            done,
	output logic            written,
	output logic [31:0]     drawn_count
);
	localparam int AW = $clog2(TILE_PIXELS);
	localparam int SW = STENCIL_WIDTH;

	logic [31:0] tag_mem [TILE_PIXELS];
	logic [31:0] dep_mem [TILE_PIXELS];
	logic [31:0] ref_mem [TILE_PIXELS];
	logic [SW-1:0] st_mem [TILE_PIXELS];

	tdtb_pkg::bk_state_t st_q, st_d;
	tdtb_pkg::word_t     w_q;
	logic [AW:0]   ptr_q, ptr_d;
	logic [AW:0]   clr_q;
	logic [31:0]   cnt_q;
	logic [31:0]   z_q, zr_q;
	logic [SW-1:0] s_q;
	logic [AW-1:0] a;
	logic [AW-1:0] ra;
	logic          pass, tpass, we_pix, we_sw, do_done, do_wr, inc, clrc, lat, clearing;
	logic          z_now_lt_not;

	assign a = (st_q == tdtb_pkg::BK_SWEEP) ? ptr_q[AW-1:0] : w_q.pixel_index[AW-1:0];
	assign clearing = !clr_q[AW];
	// a sweep starts reading at entry zero
	assign ra = (lat && q_word.is_pixel) ? q_word.pixel_index[AW-1:0] : ptr_d[AW-1:0];

	// store reads are registered and issued in the cycle before their use
	always_ff @(posedge clk) begin
		if (lat) w_q <= q_word;
		z_q  <= dep_mem[ra];
		zr_q <= ref_mem[ra];
		s_q  <= st_mem[ra];
	end

	always_comb begin
		pass  = tdtb_pkg::depth_pass(w_q.cmp_mode, w_q.depth_value, z_q);
		tpass = !tdtb_pkg::f_lt(w_q.depth_value, zr_q) &&
			!tdtb_pkg::f_eq(w_q.depth_value, z_q) && !tdtb_pkg::f_eq(w_q.depth_value, zr_q);
		z_now_lt_not = pass && ((w_q.prim_class != tdtb_pkg::PC_TRANS) || tpass);
	end

	always_comb begin
		st_d = st_q; ptr_d = ptr_q; pop = 1'b0; lat = 1'b0;
		we_pix = 1'b0; we_sw = 1'b0; do_done = 1'b0; do_wr = 1'b0; inc = 1'b0; clrc = 1'b0;
		case (st_q)
			tdtb_pkg::BK_IDLE: begin
				ptr_d = '0;
				if (q_valid && !clearing) begin
					pop = 1'b1; lat = 1'b1;
					if (q_word.is_pixel) st_d = tdtb_pkg::BK_EXEC;
					else if (q_word.is_sweep) st_d = tdtb_pkg::BK_SWEEP;
					else st_d = tdtb_pkg::BK_READ;
				end
			end
			tdtb_pkg::BK_READ: begin
				clrc = (w_q.action == tdtb_pkg::ACT_CLR_CNT);
				do_done = 1'b1; st_d = tdtb_pkg::BK_IDLE;
			end
			tdtb_pkg::BK_EXEC: begin
				we_pix = z_now_lt_not; do_wr = z_now_lt_not;
				inc = z_now_lt_not && (w_q.prim_class == tdtb_pkg::PC_TRANS);
				do_done = 1'b1; st_d = tdtb_pkg::BK_IDLE;
			end
			tdtb_pkg::BK_SWEEP: begin
				we_sw = 1'b1; ptr_d = ptr_q + 1'b1;
				if (ptr_q == (AW+1)'(TILE_PIXELS - 1)) begin
					do_done = 1'b1; st_d = tdtb_pkg::BK_IDLE;
				end
			end
			default: st_d = tdtb_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			tag_mem[clr_q[AW-1:0]] <= '0; dep_mem[clr_q[AW-1:0]] <= '0;
			ref_mem[clr_q[AW-1:0]] <= '0; st_mem[clr_q[AW-1:0]] <= '0;
		end else if (we_pix) begin
			if (w_q.prim_class == tdtb_pkg::PC_MOD) begin
				st_mem[a] <= s_q ^ SW'(2'b10);
			end else begin
				dep_mem[a] <= w_q.depth_value; tag_mem[a] <= w_q.tag_value;
			end
		end else if (we_sw) begin
			case (w_q.action)
				tdtb_pkg::ACT_CLEAR_ALL: begin
					dep_mem[a] <= w_q.depth_value; tag_mem[a] <= w_q.tag_value;
					st_mem[a] <= w_q.fill_stencil[SW-1:0];
				end
				tdtb_pkg::ACT_CLEAR_TAG: tag_mem[a] <= w_q.tag_value;
				tdtb_pkg::ACT_PEEL: begin
					ref_mem[a] <= z_q; dep_mem[a] <= w_q.depth_value;
					st_mem[a] <= w_q.fill_stencil[SW-1:0];
				end
				tdtb_pkg::ACT_ST_OR:  st_mem[a] <= s_q | (s_q >> 1);
				tdtb_pkg::ACT_ST_AND: st_mem[a] <= s_q & (s_q >> 1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tdtb_pkg::BK_IDLE; ptr_q <= '0; clr_q <= '0; cnt_q <= '0;
			done <= 1'b0; written <= 1'b0;
		end else begin
			st_q <= st_d; ptr_q <= ptr_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (clrc) cnt_q <= '0;
			else if (inc) cnt_q <= cnt_q + 32'd1;
			done <= do_done; written <= do_wr;
		end
	end

	assign drawn_count = cnt_q;
	assign idle = (st_q == tdtb_pkg::BK_IDLE);

	`TDTB_ASSERT_IMP(a_no_pop_clear, clk, arst_n, clearing, !pop, "pop during clear pass")
	`TDTB_ASSERT_IMP(a_wr_done, clk, arst_n, written, done, "written without result")
	`TDTB_ASSERT_NXT(a_pix_one, clk, arst_n, st_q == tdtb_pkg::BK_EXEC,
		st_q == tdtb_pkg::BK_IDLE, "pixel exec lasted more than a cycle")
endmodule

// ===== sv/tile_depth_tag_buffer_core.sv =====
// ------------------------------------------------------------------
// tile_depth_tag_buffer_core
// per-tile depth, tag and stencil stage with translucent layer peeling
// ------------------------------------------------------------------
// flow: a pixel test or control word is queued, popped by the back end when idle, run, and
// then raises done; a sweep raises done after its last entry, one store entry per cycle
// one word in flight; busy falls in the cycle after the done strobe, so the next word is
// accepted only after the previous one is done
// reset: after arst_n a clearing pass zeroes every store entry, a word
// accepted meanwhile waits in the queue; the receiver cannot stall the done strobe
module tile_depth_tag_buffer_core #(
	parameter int TILE_PIXELS   = tdtb_pkg::TILE_PIXELS_DEF,
	parameter int STENCIL_WIDTH = tdtb_pkg::STENCIL_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [1:0]  prim_class,
	input  logic [2:0]  ztest_func,
	input  logic [31:0] depth_value,
	input  logic [9:0]  pixel_index,
	input  logic [31:0] tag_value,
	input  logic [7:0]  fill_stencil,
	output logic        done,
	output logic        written,
	output logic [31:0] drawn_count
);
	logic            full, q_valid, pop, idle, acc;
	logic            pend_q;
	tdtb_pkg::word_t q_word;

	// one word in flight; busy until its result strobe
	assign busy = pend_q || full;
	assign acc  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (acc) pend_q <= 1'b1;
		else if (done) pend_q <= 1'b0;
	end

	// front end: classification and word queue
	tdtb_front #(.TILE_PIXELS(TILE_PIXELS), .STENCIL_WIDTH(STENCIL_WIDTH)) u_front (
		.clk, .arst_n, .push(acc), .action, .prim_class, .ztest_func, .depth_value,
		.pixel_index, .tag_value, .fill_stencil, .full, .q_valid, .q_word, .pop
	);

	// back end: store access and sweeps
	tdtb_back #(.TILE_PIXELS(TILE_PIXELS), .STENCIL_WIDTH(STENCIL_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_word, .pop, .idle, .done, .written, .drawn_count
	);

	`include "tile_depth_tag_buffer_core_defines.svh"
	`TDTB_ASSERT_IMP(a_acc_idle, clk, arst_n, acc, idle || !pend_q, "accept while pending")
	`TDTB_ASSERT_IMP(a_busy_pend, clk, arst_n, pend_q, busy, "not busy with a word pending")
	`TDTB_ASSERT_IMP(a_done_pend, clk, arst_n, done, pend_q, "done with no word pending")
endmodule

// ===== tb/testbench.sv =====
// ------------------------------------------------------------------
// testbench
// drives pixel tests, control words and tile sweeps into the tile depth and tag buffer
// and checks every done strobe against a behavioural copy of the stores
// ------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PIXELS     = tdtb_pkg::TILE_PIXELS_DEF;
	localparam logic [2:0]  ACT_UNUSED = 3'd7;
	localparam logic [2:0]  DM_ALWAYS  = 3'd7;
	localparam logic [31:0] ONE_F      = 32'h3f800000;
	localparam logic [31:0] HALF_F     = 32'h3f000000;
	localparam logic [31:0] QUART_F    = 32'h3e800000;
	localparam logic [31:0] NEG_ONE_F  = 32'hbf800000;
	localparam logic [31:0] POS_ZERO_F = 32'h00000000;
	localparam logic [31:0] NEG_ZERO_F = 32'h80000000;
	localparam logic [31:0] POS_INF_F  = 32'h7f800000;
	localparam logic [31:0] NEG_INF_F  = 32'hff800000;
	localparam logic [31:0] QNAN_F     = 32'h7fc00000;
	localparam int          N_RANDOM   = 1530;

	// one word as it goes to the block, with the sender's idle rate for it
	typedef struct {
		logic [2:0]  action;
		logic [1:0]  prim_class;
		logic [2:0]  ztest_func;
		logic [31:0] depth_value;
		logic [9:0]  pixel_index;
		logic [31:0] tag_value;
		logic [7:0]  fill_stencil;
		int          idle_pct;
	} cmd_t;

	typedef struct {
		logic        written;
		logic [31:0] drawn_count;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  action;
	logic [1:0]  prim_class;
	logic [2:0]  ztest_func;
	logic [31:0] depth_value;
	logic [9:0]  pixel_index;
	logic [31:0] tag_value;
	logic [7:0]  fill_stencil;
	logic        done;
	logic        written;
	logic [31:0] drawn_count;

	cmd_t     pending_cmds[$];
	outcome_t expected_outcomes[$];
	cmd_t     cur_cmd;
	logic     taken;
	int       n_errors;
	int       n_checked;
	int       n_written;
	int       n_sweeps;

	// shadow of the tile stores
	logic [31:0] tag_mem[PIXELS];
	logic [31:0] depth_mem[PIXELS];
	logic [31:0] ref_depth_mem[PIXELS];
	logic [7:0]  stencil_mem[PIXELS];
	logic [31:0] drawn_total;

	tile_depth_tag_buffer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.prim_class   (prim_class),
		.ztest_func   (ztest_func),
		.depth_value  (depth_value),
		.pixel_index  (pixel_index),
		.tag_value    (tag_value),
		.fill_stencil (fill_stencil),
		.done         (done),
		.written      (written),
		.drawn_count  (drawn_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ieee single compares as the c operators see them: unordered is false
	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic ord_lt(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b)) return 1'b0;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
		if (a[31] != b[31]) return a[31];
		if (a[31]) return a[30:0] > b[30:0];
		return a[30:0] < b[30:0];
	endfunction

	function automatic logic ord_eq(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b)) return 1'b0;
		return (a == b) || (a[30:0] == 31'd0 && b[30:0] == 31'd0);
	endfunction

	// each ordering mode is the negation of the opposite ordered compare, so nan
	// passes everything but never and equal
	function automatic logic depth_compare(input logic [2:0] m, input logic [31:0] v,
		input logic [31:0] z);
		logic lt;
		logic gt;
		logic eq;
		lt = ord_lt(v, z);
		gt = ord_lt(z, v);
		eq = ord_eq(v, z);
		case (m)
			tdtb_pkg::DM_NEVER:   return 1'b0;
			tdtb_pkg::DM_LESS:    return !(gt || eq);
			tdtb_pkg::DM_EQUAL:   return eq;
			tdtb_pkg::DM_LEQUAL:  return !gt;
			tdtb_pkg::DM_GREATER: return !(lt || eq);
			tdtb_pkg::DM_NEQUAL:  return !eq;
			tdtb_pkg::DM_GEQUAL:  return !lt;
			default:              return 1'b1;
		endcase
	endfunction

	// runs one word on the shadow stores and gives the written flag
	function automatic logic tile_update(input cmd_t c);
		logic [2:0]  m;
		logic [31:0] v;
		logic [31:0] z;
		logic [31:0] zr;
		int          i;
		v = c.depth_value;
		case (c.action)
			tdtb_pkg::ACT_PIXEL: begin
				m = c.ztest_func;
				if (c.prim_class == tdtb_pkg::PC_PUNCH || c.prim_class == tdtb_pkg::PC_MOD)
					m = tdtb_pkg::DM_GEQUAL;
				else if (c.prim_class == tdtb_pkg::PC_TRANS)
					m = tdtb_pkg::DM_LEQUAL;
				z = depth_mem[c.pixel_index];
				if (!depth_compare(m, v, z)) return 1'b0;
				case (c.prim_class)
					tdtb_pkg::PC_MOD: begin
						stencil_mem[c.pixel_index] ^= 8'h02;
						return 1'b1;
					end
					tdtb_pkg::PC_TRANS: begin
						zr = ref_depth_mem[c.pixel_index];
						// peeling: only strictly between reference and stored depth
						if (ord_lt(v, zr)) return 1'b0;
						if (ord_eq(v, z) || ord_eq(v, zr)) return 1'b0;
						drawn_total++;
						depth_mem[c.pixel_index] = v;
						tag_mem[c.pixel_index] = c.tag_value;
						return 1'b1;
					end
					default: begin
						depth_mem[c.pixel_index] = v;
						tag_mem[c.pixel_index] = c.tag_value;
						return 1'b1;
					end
				endcase
			end
			tdtb_pkg::ACT_CLEAR_ALL:
				for (i = 0; i < PIXELS; i++) begin
					depth_mem[i] = v;
					stencil_mem[i] = c.fill_stencil;
					tag_mem[i] = c.tag_value;
				end
			tdtb_pkg::ACT_CLEAR_TAG:
				for (i = 0; i < PIXELS; i++) tag_mem[i] = c.tag_value;
			tdtb_pkg::ACT_PEEL:
				for (i = 0; i < PIXELS; i++) begin
					ref_depth_mem[i] = depth_mem[i];
					depth_mem[i] = v;
					stencil_mem[i] = c.fill_stencil;
				end
			tdtb_pkg::ACT_ST_OR:
				for (i = 0; i < PIXELS; i++) stencil_mem[i] |= stencil_mem[i] >> 1;
			tdtb_pkg::ACT_ST_AND:
				for (i = 0; i < PIXELS; i++) stencil_mem[i] &= stencil_mem[i] >> 1;
			tdtb_pkg::ACT_CLR_CNT:
				drawn_total = 32'd0;
			default: ;
		endcase
		return 1'b0;
	endfunction

	// driver: picks up the next word at the falling edge, holds it until taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			start <= 1'b1;
		end else if (pending_cmds.size() != 0 &&
			$urandom_range(99, 0) >= pending_cmds[0].idle_pct) begin
			cur_cmd      = pending_cmds.pop_front();
			start        <= 1'b1;
			action       <= cur_cmd.action;
			prim_class   <= cur_cmd.prim_class;
			ztest_func   <= cur_cmd.ztest_func;
			depth_value  <= cur_cmd.depth_value;
			pixel_index  <= cur_cmd.pixel_index;
			tag_value    <= cur_cmd.tag_value;
			fill_stencil <= cur_cmd.fill_stencil;
		end else begin
			start <= 1'b0;
		end
	end

	// acceptance and result check at the rising edge
	always @(posedge clk) begin
		outcome_t exp_o;
		outcome_t got;
		taken <= 1'b0;
		if (arst_n && start && !busy) begin
			taken <= 1'b1;
			exp_o.written = tile_update(cur_cmd);
			exp_o.drawn_count = drawn_total;
			if (cur_cmd.action != tdtb_pkg::ACT_PIXEL) n_sweeps++;
			expected_outcomes.push_back(exp_o);
		end
		if (arst_n && done) begin
			got.written = written;
			got.drawn_count = drawn_count;
			if (expected_outcomes.size() == 0) begin
				$error("done strobe with no word outstanding");
				n_errors++;
			end else begin
				exp_o = expected_outcomes.pop_front();
				n_checked++;
				if (got.written) n_written++;
				if (got.written !== exp_o.written) begin
					$error("written: expected %0b, got %0b", exp_o.written, got.written);
					n_errors++;
				end
				if (got.drawn_count !== exp_o.drawn_count) begin
					$error("drawn_count: expected %0d, got %0d", exp_o.drawn_count,
						got.drawn_count);
					n_errors++;
				end
			end
		end
	end

	function automatic cmd_t make_cmd(input logic [2:0] a, input logic [1:0] pc,
		input logic [2:0] dm, input logic [31:0] d, input logic [9:0] px,
		input logic [31:0] tg, input logic [7:0] st, input int idle);
		cmd_t c;
		c.action = a;
		c.prim_class = pc;
		c.ztest_func = dm;
		c.depth_value = d;
		c.pixel_index = px;
		c.tag_value = tg;
		c.fill_stencil = st;
		c.idle_pct = idle;
		return c;
	endfunction

	// depths drawn from a small pool so that equal and ordered cases meet
	function automatic logic [31:0] pick_depth();
		case ($urandom_range(11, 0))
			0: return POS_ZERO_F;
			1: return NEG_ZERO_F;
			2: return ONE_F;
			3: return HALF_F;
			4: return QUART_F;
			5: return NEG_ONE_F;
			6: return POS_INF_F;
			7: return NEG_INF_F;
			8: return ($urandom_range(40, 0) == 0) ? QNAN_F | $urandom() : HALF_F;
			9: return $urandom();
			default: return {9'h07e, 23'($urandom_range(7, 0)) << 20};
		endcase
	endfunction

	initial begin
		cmd_t c;
		int   idle;
		int   k;
		int   i;
		arst_n = 1'b0;
		start = 1'b0;
		taken = 1'b0;
		action = tdtb_pkg::ACT_PIXEL;
		prim_class = tdtb_pkg::PC_OPAQUE;
		ztest_func = tdtb_pkg::DM_NEVER;
		depth_value = 32'd0;
		pixel_index = 10'd0;
		tag_value = 32'd0;
		fill_stencil = 8'd0;
		n_errors = 0;
		n_checked = 0;
		n_written = 0;
		n_sweeps = 0;
		drawn_total = 32'd0;
		for (i = 0; i < PIXELS; i++) begin
			tag_mem[i] = '0;
			depth_mem[i] = '0;
			ref_depth_mem[i] = '0;
			stencil_mem[i] = '0;
		end

		// directed: every compare mode on one pixel, field extremes, peeling
		for (k = 0; k < 8; k++)
			pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_OPAQUE, 3'(k),
				(k % 2) ? ONE_F : NEG_ZERO_F, 10'd0, 32'hffffffff, 8'hff, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_PUNCH,
			tdtb_pkg::DM_NEVER, POS_INF_F, 10'd1023, 32'h0, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_MOD, DM_ALWAYS,
			POS_INF_F, 10'd1023, 32'h5a5a5a5a, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_OPAQUE, DM_ALWAYS,
			QNAN_F, 10'd2, 32'h1, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_LESS, ONE_F, 10'd2, 32'h2, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_CLEAR_ALL, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_NEVER, ONE_F, 10'd0, 32'hffffffff, 8'hff, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_LESS, QUART_F, 10'd5, 32'h11, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PEEL, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_NEVER, ONE_F, 10'd0, 32'h0, 8'haa, 0));
		// translucent: below reference, equal to reference, between, equal to stored
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_TRANS,
			tdtb_pkg::DM_NEVER, 32'h3e000000, 10'd5, 32'h21, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_TRANS,
			tdtb_pkg::DM_NEVER, QUART_F, 10'd5, 32'h22, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_TRANS,
			tdtb_pkg::DM_NEVER, HALF_F, 10'd5, 32'h23, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_PIXEL, tdtb_pkg::PC_TRANS,
			tdtb_pkg::DM_NEVER, HALF_F, 10'd5, 32'h24, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_ST_OR, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_NEVER, 32'h0, 10'd0, 32'h0, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_ST_AND, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_NEVER, 32'h0, 10'd0, 32'h0, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_CLEAR_TAG, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_NEVER, 32'h0, 10'd0, 32'h0, 8'h0, 0));
		pending_cmds.push_back(make_cmd(tdtb_pkg::ACT_CLR_CNT, tdtb_pkg::PC_OPAQUE,
			tdtb_pkg::DM_NEVER, 32'h0, 10'd0, 32'h0, 8'h0, 0));
		pending_cmds.push_back(make_cmd(ACT_UNUSED, tdtb_pkg::PC_MOD, DM_ALWAYS, 32'hffffffff,
			10'd1023, 32'hffffffff, 8'hff, 0));

		// random: mostly pixel tests on a handful of hot pixels, sweeps now and then
		for (k = 0; k < N_RANDOM; k++) begin
			case (k * 4 / N_RANDOM)
				0:       idle = 0;
				1:       idle = 81;
				2:       idle = 0;
				default: idle = 30;
			endcase
			if (k % 200 < 20) idle = 0;
			c = make_cmd(tdtb_pkg::ACT_PIXEL, 2'($urandom_range(3, 0)),
				3'($urandom_range(7, 0)), pick_depth(),
				($urandom_range(3, 0) == 0) ? 10'($urandom()) :
				10'($urandom_range(7, 0) * 146), $urandom(), 8'($urandom()), idle);
			if ($urandom_range(99, 0) < 5)
				c.action = 3'($urandom_range(7, 1));
			pending_cmds.push_back(c);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_cmds.size() == 0 && !start);
		wait (expected_outcomes.size() == 0);
		repeat (8) @(posedge clk);
		$display("checked %0d results, %0d pixel writes, %0d sweep or control words",
			n_checked, n_written, n_sweeps);
		if (n_errors == 0 && expected_outcomes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#100ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
